FILE: hw/rtl/bmde_pkg.sv
package bmde_pkg;

    // The kernel grid is fixed by the layout of the mask register (bit row*5+col).
    localparam int KERNEL      = 5;
    localparam int TAPS        = KERNEL * KERNEL;
    localparam int TAP_IDX_W   = $clog2(TAPS);
    localparam int LINE_W      = KERNEL - 1;
    localparam int MAX_HEIGHT  = 1024;
    localparam int ROW_W       = 10;
    localparam int POS_W       = 10;
    localparam int DIM_W       = 11;
    localparam int KSZ_W       = 3;
    localparam int LAT_W       = 14;
    localparam int CFG_DATA_W  = 25;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KERNEL_MASK  = 3'd0,
        REG_KERNEL_ROWS  = 3'd1,
        REG_KERNEL_COLS  = 3'd2,
        REG_ANCHOR_ROW   = 3'd3,
        REG_ANCHOR_COL   = 3'd4,
        REG_OP_MODE      = 3'd5,
        REG_IMAGE_WIDTH  = 3'd6,
        REG_IMAGE_HEIGHT = 3'd7
    } cfg_reg_t;

    // Operation codes of the op_mode register.
    localparam logic OP_DILATE = 1'b0;
    localparam logic OP_ERODE  = 1'b1;

    // Window element [i][j]: i rows above and j columns left of the newest pixel.
    typedef logic [KERNEL-1:0][KERNEL-1:0] window_t;

    typedef struct packed {
        logic pixel_in;
        logic flush;
    } pix_item_t;

    typedef struct packed {
        logic             pixel_out;
        logic [POS_W-1:0] result_row;
        logic [POS_W-1:0] result_col;
        logic             frame_done;
    } res_item_t;

    // Configuration in the form the datapath uses: clamped sizes, the mask
    // mapped onto window coordinates and the fill latency.
    typedef struct packed {
        window_t          tap_mask;
        logic             op;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [KSZ_W-1:0] row_off;
        logic [KSZ_W-1:0] col_off;
        logic [LAT_W-1:0] latency;
    } kernel_cfg_t;

endpackage

FILE: hw/rtl/bmde_ram.sv
module bmde_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/bmde_cfg.sv
module bmde_cfg
    import bmde_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   we,
    input  logic [CFG_INDEX_W-1:0] index,
    input  logic [CFG_DATA_W-1:0]  data,
    output kernel_cfg_t            cfg
);

    localparam int DIM_MAX = (1 << DIM_W) - 1;
    localparam int W_CAP   = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
    localparam int H_CAP   = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;

    typedef struct packed {
        logic [TAPS-1:0]  mask;
        logic [KSZ_W-1:0] rows;
        logic [KSZ_W-1:0] cols;
        logic [KSZ_W-1:0] arow;
        logic [KSZ_W-1:0] acol;
        logic             op;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } raw_cfg_t;

    localparam raw_cfg_t RAW_RESET = '{
        mask:   25'd7399,
        rows:   3'd3,
        cols:   3'd3,
        arow:   3'd1,
        acol:   3'd1,
        op:     OP_DILATE,
        width:  11'd8,
        height: 11'd8
    };

    function automatic logic [KSZ_W-1:0] clamp_size(input logic [KSZ_W-1:0] v);
        logic [KSZ_W-1:0] r;
        if (v == '0)
            r = KSZ_W'(1);
        else if (v > KSZ_W'(KERNEL))
            r = KSZ_W'(KERNEL);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] cap);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > cap)
            r = cap;
        else
            r = v;
        return r;
    endfunction

    function automatic kernel_cfg_t derive(input raw_cfg_t raw);
        logic [KSZ_W-1:0]     kr;
        logic [KSZ_W-1:0]     kc;
        logic [KSZ_W-1:0]     ar;
        logic [KSZ_W-1:0]     ac;
        logic [TAP_IDX_W-1:0] src;
        kernel_cfg_t          d;
        kr = clamp_size(raw.rows);
        kc = clamp_size(raw.cols);
        ar = (raw.arow > kr - KSZ_W'(1)) ? kr - KSZ_W'(1) : raw.arow;
        ac = (raw.acol > kc - KSZ_W'(1)) ? kc - KSZ_W'(1) : raw.acol;
        d.row_off = kr - KSZ_W'(1) - ar;
        d.col_off = kc - KSZ_W'(1) - ac;
        d.width   = clamp_dim(raw.width, DIM_W'(W_CAP));
        d.height  = clamp_dim(raw.height, DIM_W'(H_CAP));
        d.op      = raw.op;
        // Window row i holds kernel row kr-1-i, window column j kernel column kc-1-j.
        for (int i = 0; i < KERNEL; i++)
        begin
            for (int j = 0; j < KERNEL; j++)
            begin
                src = TAP_IDX_W'((int'(kr) - 1 - i) * KERNEL + int'(kc) - 1 - j);
                if (i < int'(kr) && j < int'(kc))
                    d.tap_mask[i][j] = raw.mask[src];
                else
                    d.tap_mask[i][j] = 1'b0;
            end
        end
        d.latency = LAT_W'(d.row_off) * LAT_W'(d.width) + LAT_W'(d.col_off);
        return d;
    endfunction

    raw_cfg_t    raw_reg;
    raw_cfg_t    raw_next;
    kernel_cfg_t cfg_reg;

    always_comb
    begin
        raw_next = raw_reg;
        if (we)
        begin
            unique case (cfg_reg_t'(index))
                REG_KERNEL_MASK:  raw_next.mask   = data[TAPS-1:0];
                REG_KERNEL_ROWS:  raw_next.rows   = data[KSZ_W-1:0];
                REG_KERNEL_COLS:  raw_next.cols   = data[KSZ_W-1:0];
                REG_ANCHOR_ROW:   raw_next.arow   = data[KSZ_W-1:0];
                REG_ANCHOR_COL:   raw_next.acol   = data[KSZ_W-1:0];
                REG_OP_MODE:      raw_next.op     = data[0];
                REG_IMAGE_WIDTH:  raw_next.width  = data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: raw_next.height = data[DIM_W-1:0];
                default:          raw_next = raw_reg;
            endcase
        end
    end

    // The derived form is registered together with the raw value, so it is
    // valid from the edge after the write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg <= RAW_RESET;
            cfg_reg <= derive(RAW_RESET);
        end
        else if (we)
        begin
            raw_reg <= raw_next;
            cfg_reg <= derive(raw_next);
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/bmde_eval.sv
module bmde_eval
    import bmde_pkg::*;
#(
    parameter int COL_W = 10
) (
    input  window_t          win,
    input  kernel_cfg_t      cfg,
    input  logic [ROW_W-1:0] row,
    input  logic [COL_W-1:0] col,
    output logic             pixel
);

    localparam int RS_W = DIM_W + 1;
    localparam int CS_W = ((COL_W > DIM_W) ? COL_W : DIM_W) + 1;

    logic [RS_W-1:0]   row_sum;
    logic [CS_W-1:0]   col_sum;
    logic [KERNEL-1:0] row_ok;
    logic [KERNEL-1:0] col_ok;
    window_t           in_image;
    window_t           active;
    logic              any_set;
    logic              all_set;
    logic              in_any;

    assign row_sum = RS_W'(row) + RS_W'(cfg.row_off);
    assign col_sum = CS_W'(col) + CS_W'(cfg.col_off);

    // A tap lies in the image when its row and its column both do; rows above
    // the image and columns that wrapped from the neighbouring row drop out here.
    always_comb
    begin
        for (int i = 0; i < KERNEL; i++)
        begin
            row_ok[i] = (row_sum >= RS_W'(i)) &&
                        ((row_sum - RS_W'(i)) < RS_W'(cfg.height));
            col_ok[i] = (col_sum >= CS_W'(i)) &&
                        ((col_sum - CS_W'(i)) < CS_W'(cfg.width));
        end
        for (int i = 0; i < KERNEL; i++)
        begin
            for (int j = 0; j < KERNEL; j++)
            begin
                in_image[i][j] = row_ok[i] & col_ok[j];
            end
        end
    end

    assign active  = cfg.tap_mask & in_image;
    assign in_any  = |active;
    assign any_set = |(active & win);
    assign all_set = ~|(active & ~win);

    assign pixel = (cfg.op == OP_ERODE) ? (in_any & all_set) : any_set;

endmodule

FILE: hw/rtl/binary_morphology_dilate_erode.sv
// Pipeline: a pixel is taken into the input register, and the result it
// completes is written to the result register once that register is free.
// Output pixel k leaves with input item k+L, L = (rows-1-anchor_row)*width
// + (cols-1-anchor_col); throughput is one item per cycle while the result is not
// stalled, set by the single read-modify-write of the line memory per pixel.
// Reset (asynchronous) restores the default kernel and clears counters and
// window; the line memory is not cleared and needs no clearing pass.
module binary_morphology_dilate_erode
    import bmde_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pix_valid,
    output logic                   pix_stall,
    input  pix_item_t              pix_data,
    output logic                   res_valid,
    input  logic                   res_stall,
    output res_item_t              res_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = ((COL_W > DIM_W) ? COL_W : DIM_W) + 1;

    kernel_cfg_t cfg;

    logic              s1_valid_reg;
    logic              s1_bit_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic              fwd_hit_reg;
    logic [LINE_W-1:0] fwd_data_reg;
    logic              out_valid_reg;
    res_item_t         out_data_reg;
    window_t           win_reg;
    window_t           win_next;
    logic [ROW_W-1:0]  out_row_reg;
    logic [ROW_W-1:0]  out_row_next;
    logic [COL_W-1:0]  out_col_reg;
    logic [COL_W-1:0]  out_col_next;
    logic [LAT_W-1:0]  fill_reg;
    logic [LAT_W-1:0]  fill_next;
    logic [COL_W-1:0]  rd_col_reg;
    logic [COL_W-1:0]  rd_col_next;

    logic              out_free;
    logic              advance;
    logic              accept;
    logic              emit;
    logic              last;
    logic              row_end;
    logic              col_end;
    logic [COL_W-1:0]  col_base;
    logic [CMP_W-1:0]  col_inc;
    logic [COL_W-1:0]  col_step;
    logic [CMP_W-1:0]  out_col_inc;
    logic [LINE_W-1:0] ram_rdata;
    logic [LINE_W-1:0] col_word;
    logic [LINE_W-1:0] wr_word;
    logic [KERNEL-1:0] new_col;
    logic              pixel;

    bmde_cfg #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    // Handshake: the result register frees the input register, which frees the input.
    assign out_free  = !out_valid_reg || !res_stall;
    assign advance   = s1_valid_reg && out_free;
    assign pix_stall = s1_valid_reg && !out_free;
    assign accept    = pix_valid && !pix_stall;

    assign emit    = advance && (fill_reg >= cfg.latency);
    assign row_end = (DIM_W'(out_row_reg) == cfg.height - DIM_W'(1));
    assign col_end = (CMP_W'(out_col_reg) == CMP_W'(cfg.width) - CMP_W'(1));
    assign last    = emit && row_end && col_end;

    // The item after the last output pixel starts a new frame at column zero.
    assign col_base = last ? '0 : rd_col_reg;
    assign col_inc  = CMP_W'(col_base) + CMP_W'(1);
    assign col_step = (col_inc >= CMP_W'(cfg.width)) ? '0 : col_inc[COL_W-1:0];

    assign out_col_inc = CMP_W'(out_col_reg) + CMP_W'(1);

    // Each line-memory word holds, for one column, the pixels of the rows above.
    bmde_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (advance),
        .wr_addr (s1_col_reg),
        .wr_data (wr_word),
        .rd_en   (accept),
        .rd_addr (col_base),
        .rd_data (ram_rdata)
    );

    // With a one-pixel-wide image the read meets the previous item's write.
    assign col_word = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign new_col  = {col_word, s1_bit_reg};
    assign wr_word  = new_col[LINE_W-1:0];

    always_comb
    begin
        for (int i = 0; i < KERNEL; i++)
        begin
            win_next[i][0] = new_col[i];
            for (int j = 1; j < KERNEL; j++)
            begin
                win_next[i][j] = win_reg[i][j-1];
            end
        end
    end

    bmde_eval #(
        .COL_W (COL_W)
    ) u_eval (
        .win   (win_next),
        .cfg   (cfg),
        .row   (out_row_reg),
        .col   (out_col_reg),
        .pixel (pixel)
    );

    always_comb
    begin
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        fill_next    = fill_reg;
        rd_col_next  = rd_col_reg;
        if (cfg_we)
        begin
            // A configuration write restarts the frame.
            out_row_next = '0;
            out_col_next = '0;
            fill_next    = '0;
            rd_col_next  = '0;
        end
        else
        begin
            if (last)
            begin
                out_row_next = '0;
                out_col_next = '0;
                fill_next    = '0;
            end
            else if (emit)
            begin
                if (out_col_inc >= CMP_W'(cfg.width))
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_inc[COL_W-1:0];
                end
            end
            else if (advance)
            begin
                fill_next = fill_reg + LAT_W'(1);
            end
            rd_col_next = accept ? col_step : col_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            win_reg       <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            fill_reg      <= '0;
            rd_col_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= advance && (s1_col_reg == col_base);
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_free)
            begin
                out_valid_reg <= emit;
            end
            if (advance)
            begin
                win_reg <= win_next;
            end
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            fill_reg    <= fill_next;
            rd_col_reg  <= rd_col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_bit_reg   <= pix_data.pixel_in & ~pix_data.flush;
            s1_col_reg   <= col_base;
            fwd_data_reg <= wr_word;
        end
        if (emit)
        begin
            out_data_reg.pixel_out  <= pixel;
            out_data_reg.result_row <= out_row_reg;
            out_data_reg.result_col <= POS_W'(out_col_reg);
            out_data_reg.frame_done <= last;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

endmodule

FILE: hw/rtl/bmde_checker.sv
module bmde_checker
    import bmde_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      pix_stall,
    input logic      res_valid,
    input logic      res_stall,
    input res_item_t res_data
);

    logic res_xfer;

    assign res_xfer = res_valid && !res_stall;

    // A result that is held back keeps its value.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // The input is only ever held back by a full result register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> res_stall)
        else $error("input stalled without output back-pressure");

    // The transfer right after the end of a frame is the first pixel of the next.
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (res_xfer && res_data.frame_done) ##1 res_xfer |->
            (res_data.result_row == '0) && (res_data.result_col == '0))
        else $error("frame did not restart at the origin");

    // Back-to-back transfers step through the image in raster order.
    a_raster: assert property (@(posedge clk) disable iff (!rst_n)
        (res_xfer && !res_data.frame_done) ##1 res_xfer |->
            ((res_data.result_col == $past(res_data.result_col) + POS_W'(1)) &&
             (res_data.result_row == $past(res_data.result_row))) ||
            ((res_data.result_col == '0) &&
             (res_data.result_row == $past(res_data.result_row) + POS_W'(1))) ||
            ((res_data.result_col == '0) && (res_data.result_row == '0)))
        else $error("result position out of raster order");

endmodule

bind binary_morphology_dilate_erode bmde_checker u_bmde_checker (.*);

FILE: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bmde_pkg::*;

    localparam int MAX_W       = 1024;
    localparam int MAX_H       = 1024;
    localparam int HIST_DEPTH  = KERNEL * (MAX_W + 1);
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_CAP    = 100000;
    localparam int RAND_ITEMS  = 1500;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   pix_valid = 1'b0;
    logic                   pix_stall;
    pix_item_t              pix_data = '0;
    logic                   res_valid;
    logic                   res_stall = 1'b0;
    res_item_t              res_data;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    binary_morphology_dilate_erode u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Shadow copy of the configuration registers, as written.
    logic [24:0] m_mask  = 25'd7399;
    logic [2:0]  m_rows  = 3'd3;
    logic [2:0]  m_cols  = 3'd3;
    logic [2:0]  m_arow  = 3'd1;
    logic [2:0]  m_acol  = 3'd1;
    logic        m_op    = OP_DILATE;
    logic [10:0] m_width = 11'd8;
    logic [10:0] m_height = 11'd8;

    // Predicted pixel history and frame position.
    bit history [HIST_DEPTH];
    int seen    = 0;
    int out_row = 0;
    int out_col = 0;

    pix_item_t pix_queue[$];
    res_item_t pending_out[$];
    int pushed = 0;
    int taken  = 0;
    int errors = 0;

    bit src_gaps  = 1'b1;
    bit sink_busy = 1'b1;
    int src_wait  = 0;
    int sink_left = 0;
    int hold_seq  = 0;
    int hold_done = 0;
    int hold_left = 0;

    function automatic int clampi(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 80);
    endfunction

    // Upper data bits beyond a register's width are junk that must be ignored.
    function automatic logic [CFG_DATA_W-1:0] junk_above(int width);
        logic [CFG_DATA_W-1:0] j;
        j = '0;
        if ($urandom_range(0, 3) == 0) j = CFG_DATA_W'($urandom) << width;
        return j;
    endfunction

    task automatic derive_dims(output int w, output int h, output int kr, output int kc,
                               output int ar, output int ac, output int lat);
        w   = clampi(int'(m_width), 1, MAX_W);
        h   = clampi(int'(m_height), 1, MAX_H);
        kr  = clampi(int'(m_rows), 1, KERNEL);
        kc  = clampi(int'(m_cols), 1, KERNEL);
        ar  = clampi(int'(m_arow), 0, kr - 1);
        ac  = clampi(int'(m_acol), 0, kc - 1);
        lat = (kr - 1 - ar) * w + (kc - 1 - ac);
    endtask

    task automatic morph_pixel(input pix_item_t it);
        int w, h, kr, kc, ar, ac, lat;
        int ki, kj, ti, tj;
        logic px, hit_any, all_set, in_img, is_last;
        res_item_t r;
        derive_dims(w, h, kr, kc, ar, ac, lat);
        px = it.flush ? 1'b0 : it.pixel_in;
        history[seen % HIST_DEPTH] = px;
        if (seen < lat) begin
            seen++;
            return;
        end
        hit_any = 1'b0;
        all_set = 1'b1;
        in_img  = 1'b0;
        for (ki = 0; ki < kr; ki++) begin
            for (kj = 0; kj < kc; kj++) begin
                if (m_mask[ki * KERNEL + kj]) begin
                    ti = out_row + ki - ar;
                    tj = out_col + kj - ac;
                    if (ti >= 0 && ti < h && tj >= 0 && tj < w) begin
                        in_img = 1'b1;
                        if (history[(ti * w + tj) % HIST_DEPTH]) hit_any = 1'b1;
                        else all_set = 1'b0;
                    end
                end
            end
        end
        is_last      = (out_row == h - 1) && (out_col == w - 1);
        r.pixel_out  = (m_op == OP_DILATE) ? hit_any : (in_img && all_set);
        r.result_row = POS_W'(out_row);
        r.result_col = POS_W'(out_col);
        r.frame_done = is_last;
        pending_out.push_back(r);
        if (is_last) begin
            seen    = 0;
            out_row = 0;
            out_col = 0;
        end else begin
            seen++;
            if (out_col + 1 >= w) begin
                out_col = 0;
                out_row = out_row + 1;
            end else begin
                out_col = out_col + 1;
            end
        end
    endtask

    // Any register write restarts the frame in the block.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_KERNEL_MASK:  m_mask   = val[24:0];
            REG_KERNEL_ROWS:  m_rows   = val[2:0];
            REG_KERNEL_COLS:  m_cols   = val[2:0];
            REG_ANCHOR_ROW:   m_arow   = val[2:0];
            REG_ANCHOR_COL:   m_acol   = val[2:0];
            REG_OP_MODE:      m_op     = val[0];
            REG_IMAGE_WIDTH:  m_width  = val[10:0];
            REG_IMAGE_HEIGHT: m_height = val[10:0];
            default: ;
        endcase
        seen    = 0;
        out_row = 0;
        out_col = 0;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_kernel(input logic [24:0] mask, input int kr, input int kc,
                              input int ar, input int ac, input logic op,
                              input int w, input int h);
        write_reg(REG_KERNEL_MASK, CFG_DATA_W'(mask));
        write_reg(REG_KERNEL_ROWS, CFG_DATA_W'(kr[2:0]) | junk_above(KSZ_W));
        write_reg(REG_KERNEL_COLS, CFG_DATA_W'(kc[2:0]) | junk_above(KSZ_W));
        write_reg(REG_ANCHOR_ROW, CFG_DATA_W'(ar[2:0]) | junk_above(KSZ_W));
        write_reg(REG_ANCHOR_COL, CFG_DATA_W'(ac[2:0]) | junk_above(KSZ_W));
        write_reg(REG_OP_MODE, CFG_DATA_W'(op) | junk_above(1));
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w[10:0]) | junk_above(DIM_W));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h[10:0]) | junk_above(DIM_W));
    endtask

    task automatic push_pix(input logic p, input logic f);
        pix_queue.push_back('{pixel_in: p, flush: f});
        pushed++;
    endtask

    // One complete frame followed by the flush transfers that drain it.
    task automatic queue_frame(input int density, input int flush_pct);
        int w, h, kr, kc, ar, ac, lat;
        derive_dims(w, h, kr, kc, ar, ac, lat);
        for (int i = 0; i < w * h; i++) begin
            push_pix($urandom_range(0, 99) < density, $urandom_range(0, 99) < flush_pct);
        end
        for (int i = 0; i < lat; i++) begin
            push_pix($urandom_range(0, 1), 1'b1);
        end
    endtask

    task automatic wait_idle();
        int spins;
        spins = 0;
        while ((taken != pushed || pending_out.size() != 0) && spins < IDLE_CAP) begin
            @(posedge clk);
            spins++;
        end
        if (spins >= IDLE_CAP) begin
            $error("block did not drain: %0d transfers not taken", pushed - taken);
            errors++;
        end
        repeat (8) @(posedge clk);
        if (pending_out.size() != 0) begin
            $error("%0d expected results never arrived", pending_out.size());
            errors++;
            pending_out.delete();
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            pix_valid <= 1'b0;
        end else if (!pix_valid || !pix_stall) begin
            if (src_wait > 0) begin
                pix_valid <= 1'b0;
                src_wait  <= src_wait - 1;
            end else if (pix_queue.size() > 0) begin
                pix_data  <= pix_queue.pop_front();
                pix_valid <= 1'b1;
                src_wait  <= src_gaps ? pick_gap() : 0;
            end else begin
                pix_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure; a requested long hold is counted out here.
    always @(posedge clk) begin
        if (!rst_n) begin
            res_stall <= 1'b0;
        end else if (hold_left > 0) begin
            res_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_done != hold_seq) begin
            hold_done <= hold_seq;
            hold_left <= HOLD_CYCLES - 1;
            res_stall <= 1'b1;
        end else if (sink_left > 0) begin
            res_stall <= 1'b1;
            sink_left <= sink_left - 1;
        end else if (sink_busy && $urandom_range(0, 3) == 0) begin
            res_stall <= 1'b1;
            sink_left <= pick_gap();
        end else begin
            res_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        res_item_t want;
        if (rst_n) begin
            if (res_valid && !res_stall) begin
                if (pending_out.size() == 0) begin
                    $error("unexpected result at row %0d col %0d",
                           res_data.result_row, res_data.result_col);
                    errors++;
                end else begin
                    want = pending_out.pop_front();
                    if (res_data.pixel_out !== want.pixel_out) begin
                        $error("pixel_out: expected %0d, got %0d",
                               want.pixel_out, res_data.pixel_out);
                        errors++;
                    end
                    if (res_data.result_row !== want.result_row) begin
                        $error("result_row: expected %0d, got %0d",
                               want.result_row, res_data.result_row);
                        errors++;
                    end
                    if (res_data.result_col !== want.result_col) begin
                        $error("result_col: expected %0d, got %0d",
                               want.result_col, res_data.result_col);
                        errors++;
                    end
                    if (res_data.frame_done !== want.frame_done) begin
                        $error("frame_done: expected %0d, got %0d",
                               want.frame_done, res_data.frame_done);
                        errors++;
                    end
                end
            end
            if (pix_valid && !pix_stall) begin
                morph_pixel(pix_data);
                taken++;
            end
        end
    end

    initial begin
        int phase, rand_items, before_cnt, r;
        int kr, kc, ar, ac, w, h, lat, dw, dh, dkr, dkc, dar, dac;
        int density, frames, n;
        logic [24:0] mk;
        logic opv;
        bit big;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: a partial 8x8 frame under the full 3x3 dilate kernel,
        // including a flush transfer inside the frame that carries a set pixel.
        for (int i = 0; i < 12; i++) begin
            push_pix(i % 3 == 0 || i == 5, i == 5);
        end
        wait_idle();

        // Single tap on a 1x1 image: every transfer completes a frame.
        set_kernel(25'h1, 1, 1, 0, 0, OP_DILATE, 1, 1);
        push_pix(1'b1, 1'b0);
        push_pix(1'b0, 1'b0);
        push_pix(1'b1, 1'b1);
        wait_idle();
        write_reg(REG_OP_MODE, CFG_DATA_W'(OP_ERODE));
        push_pix(1'b1, 1'b0);
        push_pix(1'b0, 1'b0);
        wait_idle();

        // Full 5x5 erode anchored top left on a 1x2 image: most taps fall outside.
        set_kernel(25'h1FFFFFF, 5, 5, 0, 0, OP_ERODE, 1, 2);
        queue_frame(100, 0);
        wait_idle();

        // Out-of-range sizes and anchors, saturated by the block.
        set_kernel(25'h1FFFFFF, 0, 7, 7, 7, OP_DILATE, 0, 2047);
        push_pix(1'b1, 1'b0);
        push_pix(1'b0, 1'b0);
        wait_idle();

        // Empty mask: erode sees no tap inside the image.
        set_kernel(25'h0, 3, 3, 1, 1, OP_ERODE, 2, 1);
        queue_frame(100, 0);
        wait_idle();

        phase = 0;
        rand_items = 0;
        while (rand_items < RAND_ITEMS) begin
            big = (phase == 1 || phase == 2);
            r = $urandom_range(0, 9);
            kr = (r == 0) ? ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(6, 7))
                          : $urandom_range(1, 5);
            r = $urandom_range(0, 9);
            kc = (r == 0) ? ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(6, 7))
                          : $urandom_range(1, 5);
            ar = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
            ac = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
            r = $urandom_range(0, 5);
            if (r == 0) mk = 25'h1FFFFFF;
            else if (r == 1) mk = 25'($urandom & $urandom & $urandom);
            else mk = 25'($urandom);
            opv = $urandom_range(0, 1);
            r = $urandom_range(0, 19);
            if (r == 0) w = 0;
            else if (r < 3) w = $urandom_range(13, 40);
            else w = $urandom_range(1, 12);
            h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
            if (phase == 0) begin
                w = 8;
                h = 8;
            end else if (phase == 1) begin
                r = $urandom_range(0, 2);
                w = (r == 0) ? 1024 : ((r == 1) ? 1500 : 2047);
                h = $urandom_range(0, 1);
                // Anchoring on the bottom kernel row keeps the fill of a wide row short.
                ar = 7;
            end else if (phase == 2) begin
                w = $urandom_range(0, 1);
                h = ($urandom_range(0, 1) == 0) ? 1024 : 2047;
            end
            set_kernel(mk, kr, kc, ar, ac, opv, w, h);
            derive_dims(dw, dh, dkr, dkc, dar, dac, lat);

            src_gaps  = (phase == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            sink_busy = (phase == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            density   = $urandom_range(10, 90);
            before_cnt = pushed;

            if (!big && phase != 0 && $urandom_range(0, 4) == 0) begin
                // Broken sequence: truncated or overrunning frames with stray flushes.
                n = $urandom_range(1, clampi(2 * (dw * dh + lat) + 4, 1, 300));
                for (int i = 0; i < n; i++) begin
                    push_pix($urandom_range(0, 99) < density, $urandom_range(0, 99) < 30);
                end
            end else begin
                frames = (phase == 0) ? 3 : (big ? 1 : $urandom_range(1, 3));
                for (int f = 0; f < frames; f++) begin
                    queue_frame(density, $urandom_range(0, 3) == 0 ? 10 : 0);
                end
            end
            // The receiver holds off while the sender keeps offering transfers.
            if (phase == 0) hold_seq++;
            wait_idle();
            rand_items += pushed - before_cnt;
            phase++;
        end

        wait_idle();
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #10ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/bmde_pkg.sv
hw/rtl/bmde_ram.sv
hw/rtl/bmde_cfg.sv
hw/rtl/bmde_eval.sv
hw/rtl/binary_morphology_dilate_erode.sv
hw/rtl/bmde_checker.sv
tb/tb.sv
